// ===== rtl/left_to_right_expression_evaluator_defines.svh =====
// Assertion macros used by the expression evaluator top level.
`ifndef LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_DEFINES_SVH
`define LEFT_TO_RIGHT_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LTREXP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LTREXP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ltrexp_pkg.sv =====
// Types and character codes shared by the expression evaluator modules.
package ltrexp_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   seen;
      logic   last;
   } cmd_ctl_type;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Must be a power of two so the queue pointers wrap naturally.
   localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/ltrexp_front.sv =====
// Front end: classifies characters, builds numbers and issues operation commands.
module ltrexp_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic [7:0]               req_char_code,
   input  logic                     q_full,
   output logic                     q_push,
   output ltrexp_pkg::cmd_ctl_type  q_ctl,
   output logic [VALUE_WIDTH-1:0]   q_number
);

   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic                   seen_ff, seen_in;
   ltrexp_pkg::op_type     pend_ff, pend_in;
   logic                   accept;
   logic [7:0]             digit;

   assign accept = req_push && !q_full;
   assign digit  = req_char_code - ltrexp_pkg::CHAR_ZERO;

   always_comb begin
      cur_in        = cur_ff;
      seen_in       = seen_ff;
      pend_in       = pend_ff;
      q_push        = 1'b0;
      q_ctl.op      = pend_ff;
      q_ctl.seen    = seen_ff;
      q_ctl.last    = (req_char_code == ltrexp_pkg::CHAR_NUL);
      q_number      = cur_ff;
      if (accept) begin
         unique case (req_char_code) inside
            [ltrexp_pkg::CHAR_ZERO:ltrexp_pkg::CHAR_NINE]: begin
               cur_in  = (cur_ff << 3) + (cur_ff << 1) + VALUE_WIDTH'(digit[3:0]);
               seen_in = 1'b1;
            end
            ltrexp_pkg::CHAR_NUL, ltrexp_pkg::CHAR_PLUS, ltrexp_pkg::CHAR_MINUS,
            ltrexp_pkg::CHAR_STAR, ltrexp_pkg::CHAR_SLASH: begin
               q_push  = 1'b1;
               cur_in  = '0;
               seen_in = 1'b0;
               unique case (req_char_code)
                  ltrexp_pkg::CHAR_PLUS:  pend_in = ltrexp_pkg::OP_ADD;
                  ltrexp_pkg::CHAR_MINUS: pend_in = ltrexp_pkg::OP_SUB;
                  ltrexp_pkg::CHAR_STAR:  pend_in = ltrexp_pkg::OP_MUL;
                  ltrexp_pkg::CHAR_SLASH: pend_in = ltrexp_pkg::OP_DIV;
                  default:                pend_in = ltrexp_pkg::OP_ADD;
               endcase
            end
            default: begin
               cur_in = cur_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         seen_ff <= 1'b0;
         pend_ff <= ltrexp_pkg::OP_ADD;
      end else begin
         cur_ff  <= cur_in;
         seen_ff <= seen_in;
         pend_ff <= pend_in;
      end
   end

endmodule

// ===== rtl/ltrexp_queue.sv =====
// Short command queue between the front end and the execution unit.
module ltrexp_queue #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ltrexp_pkg::cmd_ctl_type  push_ctl,
   input  logic [VALUE_WIDTH-1:0]   push_number,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output ltrexp_pkg::cmd_ctl_type  head_ctl,
   output logic [VALUE_WIDTH-1:0]   head_number
);

   localparam int PW = $clog2(ltrexp_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(ltrexp_pkg::QUEUE_DEPTH + 1);

   ltrexp_pkg::cmd_ctl_type ctl_mem [ltrexp_pkg::QUEUE_DEPTH];
   logic [VALUE_WIDTH-1:0]  num_mem [ltrexp_pkg::QUEUE_DEPTH];
   logic [PW-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]           count_ff;
   logic                    do_push, do_pop;

   assign full        = (count_ff == CW'(ltrexp_pkg::QUEUE_DEPTH));
   assign empty       = (count_ff == '0);
   assign do_push     = push && !full;
   assign do_pop      = pop && !empty;
   assign head_ctl    = ctl_mem[rd_ptr_ff];
   assign head_number = num_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         ctl_mem[wr_ptr_ff] <= push_ctl;
         num_mem[wr_ptr_ff] <= push_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ===== rtl/ltrexp_back.sv =====
// Execution unit: applies commands to the running result with a shared iterative unit.
module ltrexp_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  ltrexp_pkg::cmd_ctl_type        q_ctl,
   input  logic [VALUE_WIDTH-1:0]         q_number,
   output logic                           q_pop,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output logic signed [VALUE_WIDTH-1:0]  rsp_value
);

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(VALUE_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DIV_END
   } state_type;

   state_type       state_ff, state_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W:0]      r_ff, r_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            neg_ff, neg_in;
   logic            last_ff, last_in;
   logic            out_valid_ff, out_valid_in;
   logic [W-1:0]    out_value_ff, out_value_in;
   logic            finish, is_last;
   logic [W-1:0]    res;
   logic [W:0]      rem_shift;
   logic            ge;

   assign rsp_empty = !out_valid_ff;
   assign rsp_value = $signed(out_value_ff);
   assign rem_shift = {r_ff[W-1:0], a_ff[W-1]};
   assign ge        = (rem_shift >= {1'b0, b_ff});

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      q_pop        = 1'b0;
      finish       = 1'b0;
      is_last      = last_ff;
      res          = acc_ff;

      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty && !(q_ctl.last && out_valid_ff)) begin
               q_pop   = 1'b1;
               last_in = q_ctl.last;
               is_last = q_ctl.last;
               finish  = 1'b1;
               if (q_ctl.seen) begin
                  unique case (q_ctl.op)
                     ltrexp_pkg::OP_ADD: res = acc_ff + q_number;
                     ltrexp_pkg::OP_SUB: res = acc_ff - q_number;
                     ltrexp_pkg::OP_MUL: begin
                        finish   = 1'b0;
                        state_in = ST_MUL;
                        a_in     = acc_ff;
                        b_in     = q_number;
                        r_in     = '0;
                        cnt_in   = '0;
                     end
                     ltrexp_pkg::OP_DIV: begin
                        if (q_number != '0) begin
                           finish   = 1'b0;
                           state_in = ST_DIV;
                           a_in     = acc_ff[W-1] ? -acc_ff : acc_ff;
                           b_in     = q_number[W-1] ? -q_number : q_number;
                           r_in     = '0;
                           cnt_in   = '0;
                           neg_in   = acc_ff[W-1] ^ q_number[W-1];
                        end
                     end
                     default: res = acc_ff;
                  endcase
               end
            end
         end
         ST_MUL: begin
            r_in   = {1'b0, b_ff[0] ? (r_ff[W-1:0] + a_ff) : r_ff[W-1:0]};
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               finish   = 1'b1;
               res      = r_in[W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            r_in   = ge ? (rem_shift - {1'b0, b_ff}) : rem_shift;
            a_in   = {a_ff[W-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            finish   = 1'b1;
            res      = neg_ff ? -a_ff : a_ff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         if (is_last) begin
            out_valid_in = 1'b1;
            out_value_in = res;
            acc_in       = '0;
         end else begin
            acc_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      r_ff         <= r_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      last_ff      <= last_in;
      out_value_ff <= out_value_in;
   end

endmodule

// ===== rtl/left_to_right_expression_evaluator.sv =====
// Top level of the left-to-right expression evaluator.
// The evaluator reads an expression one ASCII character per transfer and returns
// one result transfer when the terminating NUL arrives. Digits, spaces and other
// ignored characters are taken one per cycle by the front end while the command
// queue is not full; the front end builds the decimal number itself. Each
// operator or NUL becomes a command in a two-entry queue that the execution unit
// drains: a command without a number, an addition or a subtraction is applied
// directly from the idle state, a multiplication runs in the shift-add unit and a
// division in the restoring divider, one bit per cycle. When every operation is a
// multiplication or division, operator characters wait whenever the queue is
// full while the unit is busy. The result waits in an output register while the
// evaluator keeps accepting the next expression.
`include "left_to_right_expression_evaluator_defines.svh"

module left_to_right_expression_evaluator #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_char_code,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output logic signed [VALUE_WIDTH-1:0]  rsp_value
);

   logic                     f_push;
   ltrexp_pkg::cmd_ctl_type  f_ctl;
   logic [VALUE_WIDTH-1:0]   f_number;
   logic                     q_full, q_empty, q_pop;
   ltrexp_pkg::cmd_ctl_type  q_ctl;
   logic [VALUE_WIDTH-1:0]   q_number;

   assign req_full = q_full;

   ltrexp_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_char_code (req_char_code),
      .q_full        (q_full),
      .q_push        (f_push),
      .q_ctl         (f_ctl),
      .q_number      (f_number)
   );

   ltrexp_queue #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (f_push),
      .push_ctl    (f_ctl),
      .push_number (f_number),
      .pop         (q_pop),
      .full        (q_full),
      .empty       (q_empty),
      .head_ctl    (q_ctl),
      .head_number (q_number)
   );

   ltrexp_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_ctl     (q_ctl),
      .q_number  (q_number),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_value (rsp_value)
   );

   `LTREXP_ASSERT_IMP(a_no_push_full, clock, reset, q_full, !f_push, "command pushed into a full queue")
   `LTREXP_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, !q_empty, "command popped from an empty queue")
   `LTREXP_ASSERT_IMP(a_last_out_free, clock, reset, q_pop && q_ctl.last, rsp_empty, "final command taken while a result is still waiting")
   `LTREXP_ASSERT_NXT(a_nul_queued, clock, reset, req_push && !req_full && (req_char_code == ltrexp_pkg::CHAR_NUL), !q_empty, "terminator transfer did not reach the queue")

endmodule

// ===== sim/left_to_right_expression_evaluator_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the left-to-right expression evaluator.
module left_to_right_expression_evaluator_test;

   localparam int WIDTH = 32;
   localparam int ITEM_TARGET = 1540;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES = 200;
   localparam int MAX_REPORTS = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [7:0] req_char_code = 8'h00;
   logic rsp_pop = 1'b0;
   logic rsp_empty;
   logic signed [WIDTH-1:0] rsp_value;

   logic [WIDTH-1:0] total_acc = '0;
   logic [WIDTH-1:0] number_acc = '0;
   logic digit_seen = 1'b0;
   ltrexp_pkg::op_type model_op = ltrexp_pkg::OP_ADD;

   logic [7:0] char_queue[$];
   logic [WIDTH-1:0] result_queue[$];
   logic [WIDTH-1:0] expected_value;
   int counted_items = 0;
   int stimulus_size = 0;
   int accepted_chars = 0;
   int error_count = 0;
   int stall_cycles = 0;
   int send_gap = 0;
   int pop_gap = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_results = 1'b0;

   left_to_right_expression_evaluator #(.VALUE_WIDTH(WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_char_code(req_char_code),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_value(rsp_value)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [WIDTH-1:0] apply_op(input logic [WIDTH-1:0] acc,
         input logic [WIDTH-1:0] num, input ltrexp_pkg::op_type op);
      longint dividend;
      longint divisor;
      longint quotient;
      case (op)
         ltrexp_pkg::OP_ADD: return acc + num;
         ltrexp_pkg::OP_SUB: return acc - num;
         ltrexp_pkg::OP_MUL: return acc * num;
         default: begin
            if (num == '0) return acc;
            dividend = longint'(signed'(acc));
            divisor = longint'(signed'(num));
            quotient = dividend / divisor;
            return quotient[WIDTH-1:0];
         end
      endcase
   endfunction

   task automatic predict_char(input logic [7:0] code);
      if (code >= ltrexp_pkg::CHAR_ZERO && code <= ltrexp_pkg::CHAR_NINE) begin
         number_acc = number_acc * WIDTH'(10) + WIDTH'(code - ltrexp_pkg::CHAR_ZERO);
         digit_seen = 1'b1;
      end else if (code == ltrexp_pkg::CHAR_NUL || code == ltrexp_pkg::CHAR_PLUS ||
            code == ltrexp_pkg::CHAR_MINUS || code == ltrexp_pkg::CHAR_STAR ||
            code == ltrexp_pkg::CHAR_SLASH) begin
         if (digit_seen) total_acc = apply_op(total_acc, number_acc, model_op);
         number_acc = '0;
         digit_seen = 1'b0;
         case (code)
            ltrexp_pkg::CHAR_NUL: begin
               result_queue.push_back(total_acc);
               total_acc = '0;
               model_op = ltrexp_pkg::OP_ADD;
            end
            ltrexp_pkg::CHAR_PLUS: model_op = ltrexp_pkg::OP_ADD;
            ltrexp_pkg::CHAR_MINUS: model_op = ltrexp_pkg::OP_SUB;
            ltrexp_pkg::CHAR_STAR: model_op = ltrexp_pkg::OP_MUL;
            default: model_op = ltrexp_pkg::OP_DIV;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what);
      if (error_count < MAX_REPORTS) $display("mismatch at %0t ns: %s", $realtime, what);
      error_count++;
   endtask

   task automatic add_char(input logic [7:0] code);
      char_queue.push_back(code);
      if ((code >= ltrexp_pkg::CHAR_ZERO && code <= ltrexp_pkg::CHAR_NINE) ||
            code == ltrexp_pkg::CHAR_NUL || code == ltrexp_pkg::CHAR_PLUS ||
            code == ltrexp_pkg::CHAR_MINUS || code == ltrexp_pkg::CHAR_STAR ||
            code == ltrexp_pkg::CHAR_SLASH)
         counted_items++;
   endtask

   task automatic add_text(input string text);
      for (int i = 0; i < text.len(); i++) add_char(text[i]);
   endtask

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 3))
         0: return ltrexp_pkg::CHAR_PLUS;
         1: return ltrexp_pkg::CHAR_MINUS;
         2: return ltrexp_pkg::CHAR_STAR;
         default: return ltrexp_pkg::CHAR_SLASH;
      endcase
   endfunction

   task automatic add_number();
      int digit_count;
      digit_count = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      for (int i = 0; i < digit_count; i++) begin
         add_char(8'(ltrexp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
         if ($urandom_range(0, 29) == 0) add_char(" ");
         if ($urandom_range(0, 49) == 0) add_char(8'($urandom_range(128, 255)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full) begin
            predict_char(req_char_code);
            accepted_chars <= accepted_chars + 1;
            if ($urandom_range(0, 199) == 0) sender_idles = !sender_idles;
            send_gap = sender_idles ? $urandom_range(0, 6) : 0;
         end
         if (!(req_push && req_full)) begin
            if (send_gap == 0 && char_queue.size() != 0) begin
               req_push <= 1'b1;
               req_char_code <= char_queue.pop_front();
            end else begin
               req_push <= 1'b0;
               if (send_gap != 0) send_gap--;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (result_queue.size() == 0) begin
               report_mismatch($sformatf("value %0d with no result expected", rsp_value));
            end else begin
               expected_value = result_queue.pop_front();
               if (rsp_value !== expected_value)
                  report_mismatch($sformatf("value %0d, expected %0d", rsp_value,
                        signed'(expected_value)));
            end
            if ($urandom_range(0, 19) == 0) receiver_idles = !receiver_idles;
            pop_gap = receiver_idles ? $urandom_range(0, 6) : 0;
         end
         if (hold_results) begin
            rsp_pop <= 1'b0;
         end else if (pop_gap != 0) begin
            rsp_pop <= 1'b0;
            pop_gap--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("left_to_right_expression_evaluator regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Results are held back long enough for the evaluator to fill and refuse characters.
   initial begin
      while (accepted_chars < 400) @(posedge clock);
      hold_results <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_results <= 1'b0;
   end

   initial begin
      int term_count;
      int noise_count;
      add_char(ltrexp_pkg::CHAR_NUL);
      add_text("2147483648/4294967295");
      add_char(ltrexp_pkg::CHAR_NUL);
      add_text("1 ");
      add_char(8'hFF);
      add_text("7/0-22/4*3-+9");
      add_char(ltrexp_pkg::CHAR_NUL);
      while (counted_items < ITEM_TARGET) begin
         term_count = $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) add_char(random_operator());
         for (int t = 0; t < term_count; t++) begin
            add_number();
            if (t != term_count - 1) begin
               add_char(random_operator());
               if ($urandom_range(0, 14) == 0) add_char(random_operator());
            end
         end
         if ($urandom_range(0, 14) == 0) begin
            noise_count = $urandom_range(1, 4);
            for (int i = 0; i < noise_count; i++) add_char(8'($urandom_range(0, 255)));
         end
         add_char(ltrexp_pkg::CHAR_NUL);
      end
      stimulus_size = char_queue.size();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (accepted_chars != stimulus_size || result_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && result_queue.size() == 0) begin
         $display("left_to_right_expression_evaluator regression: pass");
      end else begin
         $display("left_to_right_expression_evaluator regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ltrexp_pkg.sv
rtl/ltrexp_front.sv
rtl/ltrexp_queue.sv
rtl/ltrexp_back.sv
rtl/left_to_right_expression_evaluator.sv
sim/left_to_right_expression_evaluator_test.sv
